// ===== hdl/lpmd_pkg.sv =====
// Shared types and constants for the length-prefixed message deframer.
package lpmd_pkg;

    // Frame layout
    localparam int HDR_BYTES = 4;      // bytes in each header word
    localparam int UID_BYTES = 16;     // uid length that marks a valid uid

    // Result queue sizing
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic signed [31:0] VERSION_RESET = 32'sd1;

    typedef enum logic [2:0] {
        PH_LEN,
        PH_VER,
        PH_UIDLEN,
        PH_UID,
        PH_PAYLEN,
        PH_PAY,
        PH_SKIP
    } phase_t;

    typedef enum logic [1:0] {
        KIND_UID = 2'd0,
        KIND_PAY = 2'd1,
        KIND_END = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [7:0]         data;
        logic [30:0]        length;
        logic signed [31:0] ftype;
        logic               uid_ok;
        logic               last;
    } result_t;

    // Up to two results per accepted byte: a data byte and an end record
    typedef struct packed {
        logic    a_vld;
        logic    b_vld;
        result_t a;
        result_t b;
    } result_pair_t;

endpackage

// ===== hdl/length_prefixed_message_deframer_core.sv =====
// Length-prefixed message deframer: top level.
// An accepted byte's results are queued and can be offered from the next cycle.
// Throughput: one byte per cycle while item_ready is high; a byte that also closes
// a frame gives two results, drained one per ready cycle through a four-entry result queue.
// item_ready is high while the queue holds at most two results.
// Reset: asynchronous, active low; frame state cleared, queue emptied, version set to 1.
module length_prefixed_message_deframer_core (
    input  logic               clk,
    input  logic               rst_n,
    // configuration: expected protocol version
    input  logic               write_enable,
    input  logic signed [31:0] write_data,
    // input stream
    input  logic               item_valid,
    output logic               item_ready,
    input  logic               action,
    input  logic [7:0]         data_byte,
    // results
    output logic               result_valid,
    input  logic               result_ready,
    output logic [1:0]         out_kind,
    output logic [7:0]         out_byte,
    output logic [30:0]        frame_length,
    output logic signed [31:0] frame_type,
    output logic               uid_valid,
    output logic               last
);

    lpmd_pkg::result_pair_t pair;
    lpmd_pkg::result_t      head;
    logic                   take;

    // input transfer goes straight into the parser state
    assign take = item_valid && item_ready;

    // Parser: header words, field counters and type word accumulation.
    // Every accepted byte yields zero, one or two results in the same cycle.
    lpmd_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .write_enable (write_enable),
        .write_data   (write_data),
        .take         (take),
        .action       (action),
        .data_byte    (data_byte),
        .pair         (pair)
    );

    // Result queue parts the two sides; input is taken while room for two results is left,
    // so input keeps flowing while the consumer stalls and the queue fills.
    lpmd_result_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair       (pair),
        .room       (item_ready),
        .head       (head),
        .head_valid (result_valid),
        .pop_ready  (result_ready)
    );

    assign out_kind     = head.kind;
    assign out_byte     = head.data;
    assign frame_length = head.length;
    assign frame_type   = head.ftype;
    assign uid_valid    = head.uid_ok;
    assign last         = head.last;

endmodule

// ===== hdl/lpmd_parser.sv =====
// Frame parser: header state, counters and accumulators, one byte per cycle while take is high.
module lpmd_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 write_enable,
    input  logic signed [31:0]   write_data,
    input  logic                 take,
    input  logic                 action,
    input  logic [7:0]           data_byte,
    output lpmd_pkg::result_pair_t pair
);

    lpmd_pkg::phase_t   phase_reg, phase_next;
    logic [30:0]        bytes_reg, bytes_next;
    logic [30:0]        declared_reg, declared_next;
    logic [31:0]        acc_reg, acc_next;
    logic [30:0]        rem_reg, rem_next;
    logic               mismatch_reg, mismatch_next;
    logic [31:0]        tacc_reg, tacc_next;
    logic [2:0]         tseen_reg, tseen_next;
    logic               uid16_reg, uid16_next;
    logic signed [31:0] version_reg;

    logic [31:0]        shifted;
    logic [30:0]        field_len;
    logic [30:0]        rem_dec;
    logic [30:0]        bytes_inc;
    logic               byte_vld;
    lpmd_pkg::kind_t    byte_kind;
    logic               frame_done;
    logic               bad;
    logic               end_vld;
    lpmd_pkg::result_t  byte_res;
    lpmd_pkg::result_t  end_res;

    assign shifted   = {acc_reg[23:0], data_byte};
    assign field_len = shifted[31] ? 31'd0 : shifted[30:0];   // negative length -> 0
    assign rem_dec   = rem_reg - 31'd1;
    assign bytes_inc = bytes_reg + 31'd1;

    always_comb
    begin
        phase_next    = phase_reg;
        bytes_next    = bytes_reg;
        declared_next = declared_reg;
        acc_next      = acc_reg;
        rem_next      = rem_reg;
        mismatch_next = mismatch_reg;
        tacc_next     = tacc_reg;
        tseen_next    = tseen_reg;
        uid16_next    = uid16_reg;
        byte_vld      = 1'b0;
        byte_kind     = lpmd_pkg::KIND_UID;
        frame_done    = 1'b0;
        bad           = 1'b0;
        end_vld       = 1'b0;
        end_res       = '0;

        if (take && !action)
        begin
            bytes_next = bytes_inc;
            case (phase_reg)
                lpmd_pkg::PH_LEN:
                begin
                    acc_next = shifted;
                    if (bytes_inc >= 31'(lpmd_pkg::HDR_BYTES))
                    begin
                        // short or negative length taken as one header word
                        declared_next = (shifted[31] || shifted < 32'(lpmd_pkg::HDR_BYTES))
                                      ? 31'(lpmd_pkg::HDR_BYTES) : shifted[30:0];
                        phase_next    = lpmd_pkg::PH_VER;
                        acc_next      = '0;
                        rem_next      = 31'(lpmd_pkg::HDR_BYTES);
                    end
                end
                lpmd_pkg::PH_VER:
                begin
                    acc_next = shifted;
                    rem_next = rem_dec;
                    if (rem_dec == '0)
                    begin
                        if (shifted != version_reg)
                        begin
                            mismatch_next = 1'b1;
                            phase_next    = lpmd_pkg::PH_SKIP;
                        end
                        else
                        begin
                            phase_next = lpmd_pkg::PH_UIDLEN;
                            rem_next   = 31'(lpmd_pkg::HDR_BYTES);
                        end
                        acc_next = '0;
                    end
                end
                lpmd_pkg::PH_UIDLEN:
                begin
                    acc_next = shifted;
                    rem_next = rem_dec;
                    if (rem_dec == '0)
                    begin
                        acc_next   = '0;
                        uid16_next = (field_len == 31'(lpmd_pkg::UID_BYTES));
                        if (field_len == '0)
                        begin
                            phase_next = lpmd_pkg::PH_PAYLEN;
                            rem_next   = 31'(lpmd_pkg::HDR_BYTES);
                        end
                        else
                        begin
                            phase_next = lpmd_pkg::PH_UID;
                            rem_next   = field_len;
                        end
                    end
                end
                lpmd_pkg::PH_UID:
                begin
                    byte_vld  = 1'b1;
                    byte_kind = lpmd_pkg::KIND_UID;
                    rem_next  = rem_dec;
                    if (rem_dec == '0)
                    begin
                        phase_next = lpmd_pkg::PH_PAYLEN;
                        rem_next   = 31'(lpmd_pkg::HDR_BYTES);
                        acc_next   = '0;
                    end
                end
                lpmd_pkg::PH_PAYLEN:
                begin
                    acc_next = shifted;
                    rem_next = rem_dec;
                    if (rem_dec == '0)
                    begin
                        acc_next   = '0;
                        rem_next   = field_len;
                        phase_next = (field_len == '0) ? lpmd_pkg::PH_SKIP
                                                       : lpmd_pkg::PH_PAY;
                    end
                end
                lpmd_pkg::PH_PAY:
                begin
                    byte_vld  = 1'b1;
                    byte_kind = lpmd_pkg::KIND_PAY;
                    if (tseen_reg < 3'd4)
                    begin
                        tacc_next  = {tacc_reg[23:0], data_byte};
                        tseen_next = tseen_reg + 3'd1;
                    end
                    rem_next = rem_dec;
                    if (rem_dec == '0)
                        phase_next = lpmd_pkg::PH_SKIP;
                end
                default:
                begin
                end
            endcase

            frame_done = (phase_next != lpmd_pkg::PH_LEN) && (bytes_next >= declared_next);
            // frame ending inside the version word reads the version as zero
            bad = (phase_next == lpmd_pkg::PH_VER) ? (version_reg != '0) : mismatch_next;
            end_vld = frame_done && !bad;

            end_res.kind   = lpmd_pkg::KIND_END;
            end_res.data   = '0;
            end_res.length = declared_next;
            end_res.ftype  = (tseen_next >= 3'd4) ? tacc_next : '0;
            end_res.uid_ok = uid16_next && (phase_next != lpmd_pkg::PH_UID);
            end_res.last   = 1'b1;
        end

        if (take && (action || frame_done))
        begin
            phase_next    = lpmd_pkg::PH_LEN;
            bytes_next    = '0;
            declared_next = '0;
            acc_next      = '0;
            rem_next      = '0;
            mismatch_next = 1'b0;
            tacc_next     = '0;
            tseen_next    = '0;
            uid16_next    = 1'b0;
        end
    end

    always_comb
    begin
        byte_res        = '0;
        byte_res.kind   = byte_kind;
        byte_res.data   = data_byte;
        byte_res.last   = !end_vld;

        pair = '0;
        if (byte_vld)
        begin
            pair.a_vld = 1'b1;
            pair.a     = byte_res;
            pair.b_vld = end_vld;
            pair.b     = end_res;
        end
        else
        begin
            pair.a_vld = end_vld;
            pair.a     = end_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= lpmd_pkg::PH_LEN;
            bytes_reg    <= '0;
            declared_reg <= '0;
            acc_reg      <= '0;
            rem_reg      <= '0;
            mismatch_reg <= 1'b0;
            tacc_reg     <= '0;
            tseen_reg    <= '0;
            uid16_reg    <= 1'b0;
            version_reg  <= lpmd_pkg::VERSION_RESET;
        end
        else
        begin
            phase_reg    <= phase_next;
            bytes_reg    <= bytes_next;
            declared_reg <= declared_next;
            acc_reg      <= acc_next;
            rem_reg      <= rem_next;
            mismatch_reg <= mismatch_next;
            tacc_reg     <= tacc_next;
            tseen_reg    <= tseen_next;
            uid16_reg    <= uid16_next;
            if (write_enable)
                version_reg <= write_data;
        end
    end

endmodule

// ===== hdl/lpmd_result_fifo.sv =====
// Result queue: takes up to two results a cycle, hands out one while pop_ready is high.
module lpmd_result_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lpmd_pkg::result_pair_t pair,
    output logic                   room,
    output lpmd_pkg::result_t      head,
    output logic                   head_valid,
    input  logic                   pop_ready
);

    lpmd_pkg::result_t           mem [lpmd_pkg::FIFO_DEPTH];
    logic [lpmd_pkg::PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [lpmd_pkg::PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [lpmd_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [lpmd_pkg::PTR_W-1:0]  wr_ptr_b;
    logic [1:0]                  push_n;
    logic                        pop;

    assign room       = count_reg <= lpmd_pkg::CNT_W'(lpmd_pkg::FIFO_DEPTH - 2);
    assign head_valid = count_reg != '0;
    assign head       = mem[rd_ptr_reg];
    assign pop        = head_valid && pop_ready;
    assign push_n     = {1'b0, pair.a_vld} + {1'b0, pair.b_vld};
    assign wr_ptr_b   = wr_ptr_reg + lpmd_pkg::PTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + lpmd_pkg::PTR_W'(push_n);
        rd_ptr_next = pop ? rd_ptr_reg + lpmd_pkg::PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + lpmd_pkg::CNT_W'(push_n)
                    - lpmd_pkg::CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (pair.a_vld)
            mem[wr_ptr_reg] <= pair.a;
        if (pair.b_vld)
            mem[wr_ptr_b] <= pair.b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/lpmd_checker.sv =====
// Port-level checks for the deframer, bound to the top level.
module lpmd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               result_valid,
    input logic               result_ready,
    input logic [1:0]         out_kind,
    input logic [30:0]        frame_length,
    input logic signed [31:0] frame_type,
    input logic               uid_valid,
    input logic               last
);

    // byte results carry no frame summary
    a_byte_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (out_kind == lpmd_pkg::KIND_UID || out_kind == lpmd_pkg::KIND_PAY)
        |-> frame_length == '0 && frame_type == '0 && !uid_valid)
        else $error("byte result with frame fields set");

    // end record always closes the byte's results and has a legal length
    a_end_record: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && out_kind == lpmd_pkg::KIND_END
        |-> last && frame_length >= 31'(lpmd_pkg::HDR_BYTES))
        else $error("malformed end record");

    // no unused kind code
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> out_kind <= lpmd_pkg::KIND_END)
        else $error("illegal result kind");

    // stalled result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(out_kind))
        else $error("stalled result withdrawn");

endmodule

bind length_prefixed_message_deframer_core lpmd_checker u_lpmd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_kind     (out_kind),
    .frame_length (frame_length),
    .frame_type   (frame_type),
    .uid_valid    (uid_valid),
    .last         (last)
);

// ===== sim/tb_top.sv =====
// Self-checking testbench for the length-prefixed message deframer core.
`timescale 1ns / 100ps

class deframer_scoreboard;
    logic [31:0]         version;
    lpmd_pkg::phase_t    phase;
    logic [31:0]         frame_bytes;
    logic [31:0]         frame_len;
    logic [31:0]         word_acc;
    logic [31:0]         field_left;
    logic [31:0]         type_acc;
    logic [2:0]          type_seen;
    logic                ver_bad;
    logic                uid_sixteen;
    lpmd_pkg::result_t   expected_results[$];
    int                  mismatch_count;

    function new();
        version        = lpmd_pkg::VERSION_RESET;
        mismatch_count = 0;
        drop_frame();
    endfunction

    function void drop_frame();
        phase       = lpmd_pkg::PH_LEN;
        frame_bytes = '0;
        frame_len   = '0;
        word_acc    = '0;
        field_left  = '0;
        type_acc    = '0;
        type_seen   = '0;
        ver_bad     = 1'b0;
        uid_sixteen = 1'b0;
    endfunction

    function lpmd_pkg::result_t make_result(lpmd_pkg::kind_t kind, logic [7:0] data,
                                            logic [30:0] length, logic [31:0] ftype,
                                            logic uid_ok);
        lpmd_pkg::result_t r;
        r.kind   = kind;
        r.data   = data;
        r.length = length;
        r.ftype  = ftype;
        r.uid_ok = uid_ok;
        r.last   = 1'b0;
        return r;
    endfunction

    // One accepted input transfer: advance the frame state, queue what it yields
    function void note_byte(logic act, logic [7:0] b);
        lpmd_pkg::result_t fresh[$];
        logic [31:0]       len;
        logic              bad;
        if (act)
        begin
            drop_frame();
            return;
        end
        frame_bytes++;
        case (phase)
            lpmd_pkg::PH_LEN:
            begin
                word_acc = {word_acc[23:0], b};
                if (frame_bytes >= lpmd_pkg::HDR_BYTES)
                begin
                    frame_len  = (word_acc[31] || word_acc < lpmd_pkg::HDR_BYTES)
                               ? lpmd_pkg::HDR_BYTES : word_acc;
                    phase      = lpmd_pkg::PH_VER;
                    word_acc   = '0;
                    field_left = lpmd_pkg::HDR_BYTES;
                end
            end
            lpmd_pkg::PH_VER:
            begin
                word_acc = {word_acc[23:0], b};
                field_left--;
                if (field_left == 0)
                begin
                    if (word_acc != version)
                    begin
                        ver_bad = 1'b1;
                        phase   = lpmd_pkg::PH_SKIP;
                    end
                    else
                    begin
                        phase      = lpmd_pkg::PH_UIDLEN;
                        field_left = lpmd_pkg::HDR_BYTES;
                    end
                    word_acc = '0;
                end
            end
            lpmd_pkg::PH_UIDLEN:
            begin
                word_acc = {word_acc[23:0], b};
                field_left--;
                if (field_left == 0)
                begin
                    len         = word_acc[31] ? 32'd0 : word_acc;
                    word_acc    = '0;
                    uid_sixteen = (len == lpmd_pkg::UID_BYTES);
                    if (len == 0)
                    begin
                        phase      = lpmd_pkg::PH_PAYLEN;
                        field_left = lpmd_pkg::HDR_BYTES;
                    end
                    else
                    begin
                        phase      = lpmd_pkg::PH_UID;
                        field_left = len;
                    end
                end
            end
            lpmd_pkg::PH_UID:
            begin
                fresh.push_back(make_result(lpmd_pkg::KIND_UID, b, '0, '0, 1'b0));
                field_left--;
                if (field_left == 0)
                begin
                    phase      = lpmd_pkg::PH_PAYLEN;
                    field_left = lpmd_pkg::HDR_BYTES;
                    word_acc   = '0;
                end
            end
            lpmd_pkg::PH_PAYLEN:
            begin
                word_acc = {word_acc[23:0], b};
                field_left--;
                if (field_left == 0)
                begin
                    len        = word_acc[31] ? 32'd0 : word_acc;
                    word_acc   = '0;
                    field_left = len;
                    phase      = (len == 0) ? lpmd_pkg::PH_SKIP : lpmd_pkg::PH_PAY;
                end
            end
            lpmd_pkg::PH_PAY:
            begin
                fresh.push_back(make_result(lpmd_pkg::KIND_PAY, b, '0, '0, 1'b0));
                if (type_seen < 3'd4)
                begin
                    type_acc = {type_acc[23:0], b};
                    type_seen++;
                end
                field_left--;
                if (field_left == 0)
                    phase = lpmd_pkg::PH_SKIP;
            end
            default:
            begin
            end
        endcase

        // Frame boundary reached: end record unless the version was wrong
        if (phase != lpmd_pkg::PH_LEN && frame_bytes >= frame_len)
        begin
            bad = ver_bad;
            if (phase == lpmd_pkg::PH_VER)
                bad = (version != 0);
            if (!bad)
                fresh.push_back(make_result(lpmd_pkg::KIND_END, '0, frame_len[30:0],
                                            (type_seen >= 3'd4) ? type_acc : 32'd0,
                                            uid_sixteen && phase != lpmd_pkg::PH_UID));
            drop_frame();
        end

        if (fresh.size() > 0)
            fresh[fresh.size() - 1].last = 1'b1;
        foreach (fresh[i])
            expected_results.push_back(fresh[i]);
    endfunction

    function void report(string what, lpmd_pkg::result_t want, lpmd_pkg::result_t got);
        if (mismatch_count < 10)
        begin
            $display("%s: exp kind=%0d byte=%02h len=%0d type=%08h uid=%b last=%b",
                     what, want.kind, want.data, want.length, want.ftype, want.uid_ok,
                     want.last);
            $display("    got kind=%0d byte=%02h len=%0d type=%08h uid=%b last=%b",
                     got.kind, got.data, got.length, got.ftype, got.uid_ok, got.last);
        end
        mismatch_count++;
    endfunction

    // One accepted output transfer against the oldest expectation
    function void check_result(logic [1:0] kind, logic [7:0] data, logic [30:0] length,
                               logic [31:0] ftype, logic uid_ok, logic lst);
        lpmd_pkg::result_t got;
        lpmd_pkg::result_t want;
        got      = make_result(lpmd_pkg::kind_t'(kind), data, length, ftype, uid_ok);
        got.last = lst;
        if (expected_results.size() == 0)
        begin
            report("unexpected result", got, got);
            return;
        end
        want = expected_results.pop_front();
        if (got !== want)
            report("result mismatch", want, got);
    endfunction
endclass

module tb_top;

    localparam int CYCLE_LIMIT  = 200000;  // well above the slowest legal run
    localparam int DRAIN_CYCLES = 10;      // settle time for bytes that yield nothing
    localparam int HOLD_CYCLES  = 200;     // long receiver hold-off
    localparam int PHASE_BYTES  = 50;      // random bytes per version setting

    // Frame shapes for the random part
    typedef enum int {
        FR_GOOD,
        FR_TRAILING,
        FR_WRONG_VERSION,
        FR_CUT,
        FR_NEG_LENGTH,
        FR_OVERRUN,
        FR_NOISE,
        FR_BULK
    } frame_shape_t;

    logic               clk;
    logic               rst_n;
    logic               write_enable;
    logic signed [31:0] write_data;
    logic               item_valid;
    logic               item_ready;
    logic               action;
    logic [7:0]         data_byte;
    logic               result_valid;
    logic               result_ready;
    logic [1:0]         out_kind;
    logic [7:0]         out_byte;
    logic [30:0]        frame_length;
    logic signed [31:0] frame_type;
    logic               uid_valid;
    logic               last;

    deframer_scoreboard sb;
    bit                 idling;         // random idle bursts on both sides
    int                 hold_requests;  // long receiver hold-offs asked for so far
    int                 byte_count;

    length_prefixed_message_deframer_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .write_enable (write_enable),
        .write_data   (write_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .action       (action),
        .data_byte    (data_byte),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_kind     (out_kind),
        .out_byte     (out_byte),
        .frame_length (frame_length),
        .frame_type   (frame_type),
        .uid_valid    (uid_valid),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Monitor: both channels sampled at the edge, before this edge's updates land
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && item_ready)
                sb.note_byte(action, data_byte);
            if (result_valid && result_ready)
                sb.check_result(out_kind, out_byte, frame_length, frame_type,
                                uid_valid, last);
        end
    end

    // Receiver: random stall bursts, plus a long hold-off on request
    initial
    begin : receiver
        int stall_left;
        int hold_left;
        int hold_seen;
        stall_left   = 0;
        hold_left    = 0;
        hold_seen    = 0;
        result_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != hold_seen)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else if (idling && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 5);
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    // Watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Regression FAIL");
        $finish;
    end

    // Offer one input transfer and hold it until accepted. Valid is left high on
    // return so that a following transfer can go back to back.
    task automatic send_item(input logic act, input logic [7:0] b);
        int gap;
        if (idling && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 6);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        action     <= act;
        data_byte  <= b;
        do
            @(posedge clk);
        while (!item_ready);
        byte_count++;
    endtask

    task automatic release_input();
        item_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            send_item(1'b0, w[i*8 +: 8]);
    endtask

    // Wait for every expected result, then let trailing no-result bytes settle
    task automatic wait_drained();
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_version(input logic [31:0] v);
        write_enable <= 1'b1;
        write_data   <= v;
        @(posedge clk);
        sb.version = v;
        write_enable <= 1'b0;
    endtask

    function automatic void push_word(ref logic [7:0] q[$], input logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            q.push_back(w[i*8 +: 8]);
    endfunction

    // Build and send one frame of the given shape against version ver
    task automatic send_frame(input logic [31:0] ver, input frame_shape_t shape);
        logic [7:0]  fb[$];
        int          uid_n;
        int          pay_n;
        int          send_n;
        logic [31:0] uid_field;
        logic [31:0] pay_field;
        logic [31:0] len_field;
        logic [31:0] ver_field;
        bit          over_uid;

        // Noise: random bytes, then a clear to get back in step
        if (shape == FR_NOISE)
        begin
            repeat ($urandom_range(1, 12)) send_item(1'b0, 8'($urandom));
            send_item(1'b1, 8'($urandom));
            return;
        end

        case ($urandom_range(0, 3))
            0:       uid_n = 0;
            1, 2:    uid_n = lpmd_pkg::UID_BYTES;
            default: uid_n = $urandom_range(1, 20);
        endcase
        pay_n = $urandom_range(0, 8);
        if (shape == FR_BULK)
        begin
            uid_n = lpmd_pkg::UID_BYTES;
            pay_n = 12;
        end
        uid_field = uid_n;
        pay_field = pay_n;
        ver_field = ver;
        over_uid  = 1'b0;

        case (shape)
            FR_WRONG_VERSION:
                ver_field = ver ^ (32'h1 << $urandom_range(0, 31));
            FR_NEG_LENGTH:
            begin
                // negative lengths count as zero, so no bytes follow
                if ($urandom_range(0, 1))
                begin
                    uid_n     = 0;
                    uid_field = 32'h8000_0000 | $urandom;
                end
                else
                begin
                    pay_n     = 0;
                    pay_field = 32'h8000_0000 | $urandom;
                end
            end
            FR_OVERRUN:
            begin
                // field runs past the frame end; the frame length cuts it
                over_uid = $urandom_range(0, 1);
                if (over_uid)
                    uid_field = uid_n + $urandom_range(1, 300);
                else
                    pay_field = pay_n + $urandom_range(1, 300);
            end
            default:
            begin
            end
        endcase

        push_word(fb, 32'h0);  // length word, filled in below
        push_word(fb, ver_field);
        push_word(fb, uid_field);
        repeat (uid_n) fb.push_back(8'($urandom));
        if (!over_uid)
        begin
            push_word(fb, pay_field);
            repeat (pay_n) fb.push_back(8'($urandom));
        end
        if (shape == FR_TRAILING)
            repeat ($urandom_range(1, 5)) fb.push_back(8'($urandom));

        len_field = fb.size();
        send_n    = fb.size();
        if (shape == FR_CUT)
        begin
            // short, negative or early lengths; short and negative count as four
            case ($urandom_range(0, 3))
                0:       len_field = 32'h8000_0000 | $urandom;
                1:       len_field = $urandom_range(0, 7);
                default: len_field = $urandom_range(0, fb.size() - 1);
            endcase
            send_n = (len_field[31] || len_field < lpmd_pkg::HDR_BYTES)
                   ? lpmd_pkg::HDR_BYTES : len_field;
        end
        {fb[0], fb[1], fb[2], fb[3]} = len_field;

        for (int i = 0; i < send_n; i++)
            send_item(1'b0, fb[i]);
    endtask

    initial
    begin : stimulus
        logic [31:0]  versions[6];
        frame_shape_t shape;
        int           phase_start;

        sb            = new();
        rst_n         = 1'b0;
        write_enable  = 1'b0;
        write_data    = '0;
        item_valid    = 1'b0;
        action        = 1'b0;
        data_byte     = '0;
        idling        = 1'b1;
        hold_requests = 0;
        byte_count    = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset version: short length ends in the version word and is dropped
        send_word(32'd2);
        // clear in the middle of a length word
        send_item(1'b0, 8'hFF);
        send_item(1'b0, 8'hFF);
        send_item(1'b1, 8'h00);
        // smallest good frame: empty uid and payload
        send_word(32'd16);
        send_word(32'd1);
        send_word(32'd0);
        send_word(32'd0);

        versions = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                     $urandom, 32'h0000_0001};

        for (int p = 0; p < 6; p++)
        begin
            release_input();
            wait_drained();
            if (p == 5)
                idling = 1'b0;  // closing stretch runs flat out
            set_version(versions[p]);

            if (p == 0)
            begin
                // version zero: a frame ending inside its version word is delivered
                send_word(32'd6);
                send_item(1'b0, 8'h00);
                send_item(1'b0, 8'h00);
            end
            if (p == 1)
            begin
                // receiver holds off while a long frame fills the result queue
                hold_requests++;
                send_frame(versions[p], FR_BULK);
            end

            phase_start = byte_count;
            while (byte_count - phase_start < PHASE_BYTES)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: shape = FR_GOOD;
                    4:          shape = FR_TRAILING;
                    5:          shape = FR_WRONG_VERSION;
                    6:          shape = FR_CUT;
                    7:          shape = FR_NEG_LENGTH;
                    8:          shape = FR_OVERRUN;
                    default:    shape = FR_NOISE;
                endcase
                send_frame(versions[p], shape);
                if ($urandom_range(0, 7) == 0)
                    send_item(1'b1, 8'($urandom));
            end
        end

        release_input();
        wait_drained();

        if (sb.mismatch_count == 0 && sb.expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
